@@ hdl/cpb_pkg.sv @@
package cpb_pkg;

   localparam logic [31:0] LANE_RB    = 32'h00ff00ff;
   localparam logic [31:0] LANE_G     = 32'h0000ff00;
   localparam logic [31:0] TOP_BYTE_MASK = 32'hff000000;
   localparam logic [31:0] RGB_MASK   = 32'h00ffffff;
   localparam logic [31:0] PRE_G_MASK = 32'h00ff0000;
   localparam logic [31:0] PRE_RB_MASK = 32'hff00ff00;
   localparam logic [31:0] SAT_LOW7   = 32'h7f7f7f7f;
   localparam logic [31:0] SAT_HIGH   = 32'h80808080;
   localparam logic [7:0]  BYTE_MAX   = 8'hff;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [1:0]  MODE_RESET    = 2'd0;
   localparam logic [7:0]  OPACITY_RESET = 8'hff;
   localparam logic [23:0] MATTE_RESET   = 24'h000000;

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_HOLD  = 2'd1,
      MODE_ADD   = 2'd2,
      MODE_MATTE = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE    = 2'd0,
      CSR_OPACITY = 2'd1,
      CSR_MATTE   = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  opacity;
      logic [23:0] matte;
   } cfg_type;

   typedef struct packed {
      logic [31:0] source_pixel;
      logic [31:0] dest_pixel;
      logic        last_pixel;
   } pix_type;

   typedef struct packed {
      mode_type    mode;
      logic        last;
      logic [23:0] base;
      logic [31:0] diff_rb;
      logic [31:0] diff_g;
      logic [7:0]  k;
      logic [23:0] src_rgb;
      logic [31:0] dst;
      logic [7:0]  sa;
   } prep_type;

   typedef struct packed {
      mode_type    mode;
      logic        last;
      logic [23:0] base;
      logic [31:0] prod_rb;
      logic [31:0] prod_g;
      logic [31:0] pre_rb;
      logic [31:0] pre_g;
      logic [31:0] dsc_rb;
      logic [31:0] dsc_g;
      logic [15:0] dasa;
      logic [7:0]  da;
      logic [7:0]  sa;
   } mul_type;

   typedef struct packed {
      mode_type    mode;
      logic        last;
      logic [23:0] lerp;
      logic [23:0] pre;
      logic [23:0] dsc;
      logic [7:0]  nda;
      logic [7:0]  da;
   } sum_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] result_pixel;
      logic        last_out;
   } out_type;

endpackage

@@ hdl/cpb_ifs.sv @@
interface cpb_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] source_pixel;
   logic [31:0] dest_pixel;
   logic        last_pixel;

   modport source (output valid, output source_pixel, output dest_pixel, output last_pixel,
                   input ready);
   modport sink (input valid, input source_pixel, input dest_pixel, input last_pixel,
                 output ready);
endinterface

interface cpb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_pixel;
   logic        last_out;

   modport source (output valid, output result_pixel, output last_out, input ready);
   modport sink (input valid, input result_pixel, input last_out, output ready);
endinterface

interface cpb_csr_if;
   logic                         valid;
   logic                         ready;
   logic [cpb_pkg::CSR_IDX_W-1:0]  index;
   logic [cpb_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/cpb_prep.sv @@
module cpb_prep (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              valid_in,
   input  cpb_pkg::pix_type  pix_in,
   input  cpb_pkg::cfg_type  cfg,
   output logic              valid_out,
   output cpb_pkg::prep_type data_out
);

   logic              valid_ff;
   cpb_pkg::prep_type data_ff;
   cpb_pkg::prep_type data_in;
   logic [31:0]       base;
   logic [31:0]       over;
   logic [7:0]        k;

   // matte mode lerps from the fixed color toward dest by dest alpha
   always_comb begin
      if (cpb_pkg::mode_type'(cfg.mode) == cpb_pkg::MODE_MATTE) begin
         base = {8'h00, cfg.matte};
         over = pix_in.dest_pixel;
         k    = pix_in.dest_pixel[31:24];
      end else begin
         base = pix_in.dest_pixel;
         over = pix_in.source_pixel;
         k    = cfg.opacity;
      end
      data_in.mode    = cpb_pkg::mode_type'(cfg.mode);
      data_in.last    = pix_in.last_pixel;
      data_in.base    = base[23:0];
      data_in.diff_rb = (over & cpb_pkg::LANE_RB) - (base & cpb_pkg::LANE_RB);
      data_in.diff_g  = (over & cpb_pkg::LANE_G) - (base & cpb_pkg::LANE_G);
      data_in.k       = k;
      data_in.src_rgb = pix_in.source_pixel[23:0];
      data_in.dst     = pix_in.dest_pixel;
      data_in.sa      = cfg.opacity;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

@@ hdl/cpb_mul.sv @@
module cpb_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              valid_in,
   input  cpb_pkg::prep_type data_in,
   output logic              valid_out,
   output cpb_pkg::mul_type  data_out
);

   logic             valid_ff;
   cpb_pkg::mul_type data_ff;
   cpb_pkg::mul_type mul_in;
   logic [31:0]      k32;
   logic [31:0]      sa32;
   logic [31:0]      inv32;
   logic [31:0]      src32;

   always_comb begin
      k32   = {24'h000000, data_in.k};
      sa32  = {24'h000000, data_in.sa};
      inv32 = {24'h000000, data_in.sa ^ cpb_pkg::BYTE_MAX};
      src32 = {8'h00, data_in.src_rgb};

      mul_in.mode    = data_in.mode;
      mul_in.last    = data_in.last;
      mul_in.base    = data_in.base;
      mul_in.prod_rb = data_in.diff_rb * k32;
      mul_in.prod_g  = data_in.diff_g * k32;
      mul_in.pre_rb  = (src32 & cpb_pkg::LANE_RB) * sa32;
      mul_in.pre_g   = (src32 & cpb_pkg::LANE_G) * sa32;
      mul_in.dsc_rb  = (data_in.dst & cpb_pkg::LANE_RB) * inv32;
      mul_in.dsc_g   = (data_in.dst & cpb_pkg::LANE_G) * inv32;
      mul_in.dasa    = {8'h00, data_in.dst[31:24]} * {8'h00, data_in.sa};
      mul_in.da      = data_in.dst[31:24];
      mul_in.sa      = data_in.sa;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= mul_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

@@ hdl/cpb_sum.sv @@
module cpb_sum (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  logic             valid_in,
   input  cpb_pkg::mul_type data_in,
   output logic             valid_out,
   output cpb_pkg::sum_type data_out
);

   logic             valid_ff;
   cpb_pkg::sum_type data_ff;
   cpb_pkg::sum_type sum_in;
   logic [31:0]      base32;
   logic [31:0]      lerp32;
   logic [31:0]      pre32;
   logic [31:0]      dsc32;
   logic [8:0]       nda_raw;
   logic [8:0]       nda_fix;

   always_comb begin
      base32 = {8'h00, data_in.base};
      lerp32 = (((base32 & cpb_pkg::LANE_RB) + (data_in.prod_rb >> 8)) & cpb_pkg::LANE_RB)
             | (((base32 & cpb_pkg::LANE_G) + (data_in.prod_g >> 8)) & cpb_pkg::LANE_G);
      pre32  = (((data_in.pre_g & cpb_pkg::PRE_G_MASK)
               + (data_in.pre_rb & cpb_pkg::PRE_RB_MASK)) >> 8) & cpb_pkg::RGB_MASK;
      dsc32  = ((data_in.dsc_rb >> 8) & cpb_pkg::LANE_RB)
             + ((data_in.dsc_g >> 8) & cpb_pkg::LANE_G);
      // union of alphas, then fold the 256 case back to 255
      nda_raw = {1'b0, data_in.da} + {1'b0, data_in.sa} - {1'b0, data_in.dasa[15:8]};
      nda_fix = nda_raw - (nda_raw >> 8);

      sum_in.mode = data_in.mode;
      sum_in.last = data_in.last;
      sum_in.lerp = lerp32[23:0];
      sum_in.pre  = pre32[23:0];
      sum_in.dsc  = dsc32[23:0];
      sum_in.nda  = nda_fix[7:0];
      sum_in.da   = data_in.da;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= sum_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

@@ hdl/cpb_sat.sv @@
module cpb_sat (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  logic             valid_in,
   input  cpb_pkg::sum_type data_in,
   output logic             valid_out,
   output cpb_pkg::out_type data_out
);

   logic             valid_ff;
   cpb_pkg::out_type data_ff;
   cpb_pkg::out_type out_in;
   logic [31:0]      pre32;
   logic [31:0]      dsc32;
   logic [31:0]      lerp32;
   logic [31:0]      carry;
   logic [31:0]      fill;
   logic [31:0]      add32;

   always_comb begin
      pre32  = {8'h00, data_in.pre};
      dsc32  = {8'h00, data_in.dsc};
      lerp32 = {8'h00, data_in.lerp};
      // per-byte overflow mask, then saturate those bytes to 0xff
      carry = ((dsc32 & pre32) + (((dsc32 ^ pre32) >> 1) & cpb_pkg::SAT_LOW7))
            & cpb_pkg::SAT_HIGH;
      fill  = (carry << 1) - (carry >> 7);
      add32 = (((dsc32 + pre32 - fill) | fill) & cpb_pkg::RGB_MASK)
            | {data_in.nda, 24'h000000};

      out_in.mode     = data_in.mode;
      out_in.last_out = data_in.last;
      case (data_in.mode)
         cpb_pkg::MODE_PLAIN: out_in.result_pixel = lerp32;
         cpb_pkg::MODE_HOLD:  out_in.result_pixel = lerp32 | {data_in.da, 24'h000000};
         cpb_pkg::MODE_ADD:   out_in.result_pixel = add32;
         cpb_pkg::MODE_MATTE: out_in.result_pixel = lerp32 | cpb_pkg::TOP_BYTE_MASK;
         default:             out_in.result_pixel = lerp32;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= out_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

   a_matte_alpha: assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.mode == cpb_pkg::MODE_MATTE |-> data_ff.result_pixel[31:24] == 8'hff)
      else $error("matte result alpha not opaque");

   a_plain_alpha: assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.mode == cpb_pkg::MODE_PLAIN |-> data_ff.result_pixel[31:24] == 8'h00)
      else $error("plain result alpha not zero");

endmodule

@@ hdl/constant_opacity_pixel_blend_top.sv @@
// channel   port      dir   payload
// input     req_bus   sink  source_pixel[31:0], dest_pixel[31:0], last_pixel
// result    rsp_bus   src   result_pixel[31:0], last_out
// config    csr_bus   sink  index[1:0], data[23:0] (0 mode, 1 opacity, 2 matte)
//
// four register stages: operand select, packed multiplies, lane sums, saturate/select
// one pixel per clock sustained while rsp_bus.ready is high, rsp_bus.valid rises once the beat reaches saturate/select
// synchronous active-high reset clears stage valids and loads register defaults
// each stage loads whenever it is empty or the one after it moves, so bubbles collapse
// and a stalled rsp_bus holds its beat while earlier stages keep filling
module constant_opacity_pixel_blend_top (
   input logic clock,
   input logic reset,
   cpb_req_if.sink   req_bus,
   cpb_rsp_if.source rsp_bus,
   cpb_csr_if.sink   csr_bus
);

   logic [1:0]  mode_ff;
   logic [7:0]  opacity_ff;
   logic [23:0] matte_ff;

   cpb_pkg::cfg_type  cfg;
   cpb_pkg::pix_type  pix;
   cpb_pkg::prep_type prep_data;
   cpb_pkg::mul_type  mul_data;
   cpb_pkg::sum_type  sum_data;
   cpb_pkg::out_type  out_data;

   logic v1, v2, v3, v4;
   logic ld1, ld2, ld3, ld4;
   logic req_beat;
   logic csr_beat;

   assign csr_bus.ready = 1'b1;
   assign csr_beat      = csr_bus.valid && csr_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= cpb_pkg::MODE_RESET;
         opacity_ff <= cpb_pkg::OPACITY_RESET;
         matte_ff   <= cpb_pkg::MATTE_RESET;
      end else if (csr_beat) begin
         case (cpb_pkg::csr_idx_type'(csr_bus.index))
            cpb_pkg::CSR_MODE:    mode_ff    <= csr_bus.data[1:0];
            cpb_pkg::CSR_OPACITY: opacity_ff <= csr_bus.data[7:0];
            cpb_pkg::CSR_MATTE:   matte_ff   <= csr_bus.data;
            default: ;
         endcase
      end
   end

   assign cfg.mode    = mode_ff;
   assign cfg.opacity = opacity_ff;
   assign cfg.matte   = matte_ff;

   assign pix.source_pixel = req_bus.source_pixel;
   assign pix.dest_pixel   = req_bus.dest_pixel;
   assign pix.last_pixel   = req_bus.last_pixel;

   // stage load chain from the output back
   assign ld4 = !v4 || rsp_bus.ready;
   assign ld3 = !v3 || ld4;
   assign ld2 = !v2 || ld3;
   assign ld1 = !v1 || ld2;

   assign req_bus.ready = ld1;
   assign req_beat      = req_bus.valid && ld1;

   cpb_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .load      (ld1),
      .valid_in  (req_bus.valid),
      .pix_in    (pix),
      .cfg       (cfg),
      .valid_out (v1),
      .data_out  (prep_data)
   );

   cpb_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .load      (ld2),
      .valid_in  (v1),
      .data_in   (prep_data),
      .valid_out (v2),
      .data_out  (mul_data)
   );

   cpb_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .load      (ld3),
      .valid_in  (v2),
      .data_in   (mul_data),
      .valid_out (v3),
      .data_out  (sum_data)
   );

   cpb_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .load      (ld4),
      .valid_in  (v3),
      .data_in   (sum_data),
      .valid_out (v4),
      .data_out  (out_data)
   );

   assign rsp_bus.valid        = v4;
   assign rsp_bus.result_pixel = out_data.result_pixel;
   assign rsp_bus.last_out     = out_data.last_out;

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> v1 && prep_data.last == $past(req_bus.last_pixel))
      else $error("accepted beat did not enter first stage");

   a_stage1_hold: assert property (@(posedge clock) disable iff (reset)
      v1 && !ld2 |=> v1 && $stable(prep_data))
      else $error("stalled first stage lost its beat");

   a_stage3_hold: assert property (@(posedge clock) disable iff (reset)
      v3 && !ld4 |=> v3 && $stable(sum_data))
      else $error("stalled third stage lost its beat");

   a_mode_write: assert property (@(posedge clock) disable iff (reset)
      csr_beat && csr_bus.index == cpb_pkg::CSR_MODE |=> mode_ff == $past(csr_bus.data[1:0]))
      else $error("mode register write not taken");

endmodule
